>>> design/obg_pkg.sv
// shared constants, types and helper functions of the broadcast offset generator
package obg_pkg;

  localparam int MAX_RANK    = 4;
  localparam int DIM_BITS    = 16;
  localparam int OFFSET_BITS = 32;
  localparam int NUM_OPS     = 3;
  localparam int SHAPE_BITS  = 64;
  localparam int OUT_BITS    = 32;
  localparam int IDX_BITS    = 2;
  localparam int STATUS_BITS = 2;
  localparam int IN_BITS     = 8;
  localparam int TDATA_BITS  = 4 * OUT_BITS;
  localparam int STEP_BITS   = $clog2(MAX_RANK + 2);

  // every dim of 1
  localparam logic [SHAPE_BITS-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } gen_status_t;

  // derived shape data handed from the setup sequencer to the odometer
  typedef struct packed {
    logic [MAX_RANK-1:0][DIM_BITS-1:0]               dims;
    logic [NUM_OPS-1:0][MAX_RANK:0][OFFSET_BITS-1:0] delta;
    logic [OFFSET_BITS-1:0]                          cnt_m1;
    gen_status_t                                     status;
  } gen_cfg_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] element_index;
    logic [OUT_BITS-1:0] offset_first;
    logic [OUT_BITS-1:0] offset_second;
    logic [OUT_BITS-1:0] offset_third;
    logic                last;
    gen_status_t         status;
  } result_t;

  // dim of one axis, axes past the register read as 1
  function automatic logic [DIM_BITS-1:0] dim_of(input logic [SHAPE_BITS-1:0] shape,
                                                 input int axis);
    logic [SHAPE_BITS+DIM_BITS-1:0] ext;
    ext = {{DIM_BITS{1'b0}}, shape};
    if (axis * DIM_BITS >= SHAPE_BITS) begin
      return DIM_BITS'(1);
    end
    return ext[axis*DIM_BITS +: DIM_BITS];
  endfunction

  // broadcast rule, msb flags a mismatch, mismatching axis keeps the left dim
  function automatic logic [DIM_BITS:0] combine(input logic [DIM_BITS-1:0] a,
                                                input logic [DIM_BITS-1:0] b);
    if (a == b || b == DIM_BITS'(1)) begin
      return {1'b0, a};
    end
    if (a == DIM_BITS'(1)) begin
      return {1'b0, b};
    end
    return {1'b1, a};
  endfunction

endpackage

>>> design/obg_derive.sv
// shape registers and the per-axis setup sequencer for output dims, steps and status
module obg_derive (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [obg_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [obg_pkg::SHAPE_BITS-1:0]  cfg_data,
  output logic                            cfg_hit,
  output logic                            busy,
  output obg_pkg::gen_cfg_t               gen
);
  import obg_pkg::*;

  logic [SHAPE_BITS-1:0]             shape [NUM_OPS];
  logic [STEP_BITS-1:0]              step;
  logic [OFFSET_BITS:0]              prod;
  logic                              over;
  logic [OFFSET_BITS-1:0]            st [NUM_OPS];
  logic [OFFSET_BITS-1:0]            stride_r [NUM_OPS];
  logic [OFFSET_BITS-1:0]            wrap_r [NUM_OPS];
  logic [OFFSET_BITS-1:0]            acc [NUM_OPS];

  logic [DIM_BITS-1:0]               odim [MAX_RANK];
  logic                              bad;
  logic                              empty;
  logic [DIM_BITS-1:0]               cur_dim;
  logic [DIM_BITS-1:0]               op_dim [NUM_OPS];
  logic [OFFSET_BITS+DIM_BITS:0]     prod_mul;
  logic [OFFSET_BITS+DIM_BITS-1:0]   st_mul [NUM_OPS];
  logic [OFFSET_BITS+DIM_BITS-1:0]   wrap_mul [NUM_OPS];
  logic [OFFSET_BITS+DIM_BITS:0]     limit;
  gen_status_t                       status_next;

  assign cfg_hit = cfg_valid && ({1'b0, cfg_index} < (IDX_BITS + 1)'(NUM_OPS));
  assign limit   = (OFFSET_BITS + DIM_BITS + 1)'(1) << OFFSET_BITS;

  // broadcast output shape and flags
  always_comb begin
    logic [DIM_BITS:0] ab;
    logic [DIM_BITS:0] abc;
    bad   = 1'b0;
    empty = 1'b0;
    for (int d = 0; d < MAX_RANK; d++) begin
      ab      = combine(dim_of(shape[0], d), dim_of(shape[1], d));
      abc     = combine(ab[DIM_BITS-1:0], dim_of(shape[2], d));
      odim[d] = abc[DIM_BITS-1:0];
      bad     = bad | ab[DIM_BITS] | abc[DIM_BITS];
      empty   = empty | (abc[DIM_BITS-1:0] == '0);
    end
  end

  // dims of the axis being worked on
  always_comb begin
    cur_dim = '0;
    for (int k = 0; k < NUM_OPS; k++) begin
      op_dim[k] = '0;
    end
    for (int d = 0; d < MAX_RANK; d++) begin
      if (step == STEP_BITS'(d)) begin
        cur_dim = odim[d];
        for (int k = 0; k < NUM_OPS; k++) begin
          op_dim[k] = dim_of(shape[k], d);
        end
      end
    end
  end

  assign prod_mul = prod * cur_dim;
  always_comb begin
    for (int k = 0; k < NUM_OPS; k++) begin
      st_mul[k]   = st[k] * op_dim[k];
      wrap_mul[k] = st[k] * cur_dim;
    end
  end

  always_comb begin
    if (bad) begin
      status_next = ST_MISMATCH;
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else if (over) begin
      status_next = ST_OVERFLOW;
    end else begin
      status_next = ST_OK;
    end
  end

  // control and derived outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_OPS; k++) begin
        shape[k] <= SHAPE_RESET;
      end
      busy <= 1'b0;
      step <= '0;
      for (int d = 0; d < MAX_RANK; d++) begin
        gen.dims[d] <= DIM_BITS'(1);
      end
      gen.delta  <= '0;
      gen.cnt_m1 <= '0;
      gen.status <= ST_OK;
    end else if (cfg_hit) begin
      for (int k = 0; k < NUM_OPS; k++) begin
        if (cfg_index == IDX_BITS'(k)) begin
          shape[k] <= cfg_data;
        end
      end
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_BITS'(1);
      for (int j = 0; j < MAX_RANK; j++) begin
        if (step == STEP_BITS'(j + 1)) begin
          for (int k = 0; k < NUM_OPS; k++) begin
            gen.delta[k][j] <= acc[k] + stride_r[k];
          end
        end
      end
      if (step == STEP_BITS'(MAX_RANK + 1)) begin
        for (int k = 0; k < NUM_OPS; k++) begin
          gen.delta[k][MAX_RANK] <= acc[k];
        end
        for (int d = 0; d < MAX_RANK; d++) begin
          gen.dims[d] <= odim[d];
        end
        gen.cnt_m1 <= OFFSET_BITS'(prod - (OFFSET_BITS + 1)'(1));
        gen.status <= status_next;
        busy       <= 1'b0;
      end
    end
  end

  // working registers, one axis per cycle, each axis accumulated in the cycle after its multiply
  always_ff @(posedge clk) begin
    if (cfg_hit) begin
      prod <= (OFFSET_BITS + 1)'(1);
      over <= 1'b0;
      for (int k = 0; k < NUM_OPS; k++) begin
        st[k]  <= OFFSET_BITS'(1);
        acc[k] <= '0;
      end
    end else if (busy) begin
      if (step < STEP_BITS'(MAX_RANK)) begin
        if (!over) begin
          if (prod_mul > limit) begin
            over <= 1'b1;
          end else begin
            prod <= (OFFSET_BITS + 1)'(prod_mul);
          end
        end
        for (int k = 0; k < NUM_OPS; k++) begin
          if (op_dim[k] == DIM_BITS'(1)) begin
            stride_r[k] <= '0;
            wrap_r[k]   <= '0;
          end else begin
            stride_r[k] <= st[k];
            wrap_r[k]   <= OFFSET_BITS'(wrap_mul[k]);
          end
          st[k] <= OFFSET_BITS'(st_mul[k]);
        end
      end
      if (step != '0 && step <= STEP_BITS'(MAX_RANK)) begin
        for (int k = 0; k < NUM_OPS; k++) begin
          acc[k] <= acc[k] + stride_r[k] - wrap_r[k];
        end
      end
    end
  end

endmodule

>>> design/obg_odometer.sv
// output coordinate odometer with running operand offsets and flat index
module obg_odometer (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               step_en,
  input  logic               restart,
  input  obg_pkg::gen_cfg_t  gen,
  output obg_pkg::result_t   res
);
  import obg_pkg::*;

  logic [DIM_BITS-1:0]    coord [MAX_RANK];
  logic [OFFSET_BITS-1:0] offs [NUM_OPS];
  logic [OFFSET_BITS-1:0] index;

  logic [DIM_BITS-1:0]    base_coord [MAX_RANK];
  logic [OFFSET_BITS-1:0] base_offs [NUM_OPS];
  logic [OFFSET_BITS-1:0] base_index;
  logic [DIM_BITS-1:0]    coord_inc [MAX_RANK];
  logic [MAX_RANK-1:0]    wraps;
  logic [MAX_RANK:0]      carry;
  logic [MAX_RANK:0]      stop;
  logic [OFFSET_BITS-1:0] dsel [NUM_OPS];
  logic [DIM_BITS-1:0]    coord_next [MAX_RANK];
  logic [OFFSET_BITS-1:0] offs_next [NUM_OPS];
  logic [OFFSET_BITS-1:0] index_next;
  logic                   at_last;

  // a restart beat works from element zero
  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      base_coord[d] = restart ? '0 : coord[d];
    end
    for (int k = 0; k < NUM_OPS; k++) begin
      base_offs[k] = restart ? '0 : offs[k];
    end
    base_index = restart ? '0 : index;
  end

  // carry chain, stop marks the axis that takes the increment
  always_comb begin
    carry[0] = 1'b1;
    for (int d = 0; d < MAX_RANK; d++) begin
      coord_inc[d] = base_coord[d] + DIM_BITS'(1);
      wraps[d]     = coord_inc[d] >= gen.dims[d];
      carry[d+1]   = carry[d] & wraps[d];
      stop[d]      = carry[d] & ~wraps[d];
      if (carry[d]) begin
        coord_next[d] = wraps[d] ? '0 : coord_inc[d];
      end else begin
        coord_next[d] = base_coord[d];
      end
    end
    stop[MAX_RANK] = carry[MAX_RANK];
  end

  // offset step is prebuilt per carry depth
  always_comb begin
    for (int k = 0; k < NUM_OPS; k++) begin
      dsel[k] = '0;
      for (int j = 0; j <= MAX_RANK; j++) begin
        if (stop[j]) begin
          dsel[k] = dsel[k] | gen.delta[k][j];
        end
      end
      offs_next[k] = base_offs[k] + dsel[k];
    end
  end

  assign at_last    = base_index == gen.cnt_m1;
  assign index_next = at_last ? '0 : base_index + OFFSET_BITS'(1);

  always_comb begin
    if (gen.status != ST_OK) begin
      res.element_index = '0;
      res.offset_first  = '0;
      res.offset_second = '0;
      res.offset_third  = '0;
      res.last          = 1'b1;
    end else begin
      res.element_index = OUT_BITS'(base_index);
      res.offset_first  = OUT_BITS'(base_offs[0]);
      res.offset_second = OUT_BITS'(base_offs[1]);
      res.offset_third  = OUT_BITS'(base_offs[2]);
      res.last          = at_last;
    end
    res.status = gen.status;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int d = 0; d < MAX_RANK; d++) begin
        coord[d] <= '0;
      end
      for (int k = 0; k < NUM_OPS; k++) begin
        offs[k] <= '0;
      end
      index <= '0;
    end else if (step_en) begin
      if (gen.status == ST_OK) begin
        for (int d = 0; d < MAX_RANK; d++) begin
          coord[d] <= coord_next[d];
        end
        for (int k = 0; k < NUM_OPS; k++) begin
          offs[k] <= offs_next[k];
        end
        index <= index_next;
      end else begin
        for (int d = 0; d < MAX_RANK; d++) begin
          coord[d] <= base_coord[d];
        end
        for (int k = 0; k < NUM_OPS; k++) begin
          offs[k] <= base_offs[k];
        end
        index <= base_index;
      end
    end
  end

endmodule

>>> design/broadcast_offset_generator_unit.sv
// top level: broadcast offset generator with stream ports and a two-entry result buffer
// an accepted step beat registers its result in the output register or the skid entry
// throughput: one step beat per cycle while s_tready is high, the odometer advances in
// a single pass; a shape write stalls s_tready while the setup sequencer
// walks the axes, one multiply set per axis
// reset: shapes go to all dims 1, odometer to element zero, result buffer empty
module broadcast_offset_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  // step beats
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [obg_pkg::IN_BITS-1:0]         s_tdata,   // restart, zero pad
  // result beats
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [obg_pkg::TDATA_BITS-1:0]      m_tdata,   // element_index, offset_first,
                                                         // offset_second, offset_third
  output logic                                m_tlast,
  output logic [obg_pkg::STATUS_BITS-1:0]     m_tuser,   // status
  // shape register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [obg_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [obg_pkg::SHAPE_BITS-1:0]      cfg_data
);
  import obg_pkg::*;

  logic     busy;
  logic     cfg_hit;
  gen_cfg_t gen;
  result_t  res;
  logic     in_beat;
  logic     out_beat;

  // output register plus skid entry
  result_t  out_r;
  result_t  skid_r;
  logic     out_valid;
  logic     skid_valid;

  // writes are always taken, a write to a listed shape register restarts setup
  assign cfg_ready = 1'b1;

  // input stalls during setup or once the skid entry is holding a beat
  assign s_tready = !busy && !skid_valid;
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  obg_derive u_derive (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_hit   (cfg_hit),
    .busy      (busy),
    .gen       (gen)
  );

  // a shape write to a listed register sends the odometer back to element zero
  obg_odometer u_odometer (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_hit),
    .step_en (in_beat),
    .restart (s_tdata[0]),
    .gen     (gen),
    .res     (res)
  );

  // control of the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_beat) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!in_beat) begin
          out_valid <= 1'b0;
        end
      end
      if (in_beat) begin
        if (out_valid && !out_beat) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // payload of the result buffer
  always_ff @(posedge clk) begin
    if (out_beat && skid_valid) begin
      out_r <= skid_r;
    end
    if (in_beat) begin
      if (!out_valid || out_beat) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_r.offset_third, out_r.offset_second,
                     out_r.offset_first, out_r.element_index};
  assign m_tlast  = out_r.last;
  assign m_tuser  = out_r.status;

  // skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // no step is taken while setup is running
  a_no_step_in_setup: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("step beat accepted during setup");

  // a write to a listed shape register starts setup
  a_write_starts_setup: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> busy)
    else $error("shape write did not start setup");

  // error results always close the run
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
    else $error("error result without last");

endmodule
